@@ rtl/core/prw_pkg.sv @@
// Package for the capture record walker: phase encoding, stream item and
// result structs, header layout constants and the byte merge helper.
// No dependencies.
`default_nettype none

package prw_pkg;

	// Bytes of global file header skipped at the start of a capture
	localparam int GLOBAL_HEADER_BYTES = 24;
	localparam logic [4:0] GHDR_LEN = 5'(GLOBAL_HEADER_BYTES & 31);

	// Record header is four 32-bit little-endian words
	localparam logic [3:0] RHDR_LAST = 4'd15;

	// Word slots inside the record header
	localparam logic [1:0] WSEL_SECONDS  = 2'd0;
	localparam logic [1:0] WSEL_FRACTION = 2'd1;
	localparam logic [1:0] WSEL_CAPTURED = 2'd2;
	localparam logic [1:0] WSEL_ORIGINAL = 2'd3;

	localparam int RES_TDATA_W = 192;

	typedef enum logic [1:0] {
		PH_GLOBAL  = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} prw_phase_t;

	// One input byte of the capture stream
	typedef struct packed {
		logic       start_flag;
		logic [7:0] data_byte;
	} prw_item_t;

	// One parsed record header
	typedef struct packed {
		logic [31:0] payload_offset;
		logic [31:0] original_length;
		logic [31:0] captured_length;
		logic [31:0] ts_fraction;
		logic [31:0] ts_seconds;
		logic [31:0] record_number;
	} prw_result_t;

	// Place one byte into a little-endian word; lane 0 starts a fresh word
	function automatic logic [31:0] merge_byte(input logic [31:0] word,
		input logic [1:0] lane, input logic [7:0] b);
		logic [31:0] res;
		res = word;
		unique case (lane)
			2'd0: res = {24'h000000, b};
			2'd1: res[15:8] = b;
			2'd2: res[23:16] = b;
			2'd3: res[31:24] = b;
			default: res = word;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/prw_in_stage.sv @@
// Input register of the record walker: captures one stream byte per
// transaction and holds it until the parser consumes it. Uses prw_pkg.
`default_nettype none

module prw_in_stage
	import prw_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire prw_item_t in_item,
	output logic           valid_s1,
	output prw_item_t      item_s1,
	input  wire logic      consume
);

	logic load;

	// Free when empty or when the held byte leaves this cycle
	assign in_ready = !valid_s1 || consume;
	assign load     = in_valid && in_ready;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/prw_parser.sv @@
// Parse state of the record walker: phase tracking, header word assembly,
// payload skip count, record count and file offset. Uses prw_pkg.
`default_nettype none

module prw_parser
	import prw_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      valid_s1,
	input  wire prw_item_t item_s1,
	output logic           consume,
	input  wire logic      res_ready,
	output logic           res_load,
	output prw_result_t    res_data
);

	prw_phase_t  phase_q, phase_c;
	logic [4:0]  cnt_q, cnt_c;
	logic [31:0] w_sec_q, w_frac_q, w_cap_q, w_orig_q;
	logic [31:0] w_sec_c, w_frac_c, w_cap_c, w_orig_c;
	logic [31:0] remain_q, remain_c;
	logic [31:0] rec_total_q, rec_total_c;
	logic [31:0] offset_q, offset_c;
	logic        emit_c;

	// Next state for the byte in the input register
	always_comb begin
		logic [3:0]  c;
		logic [4:0]  cnt_inc;
		logic [31:0] rem_dec;
		logic [31:0] offs;
		c       = 4'd0;
		cnt_inc = 5'd0;
		rem_dec = 32'd0;
		offs    = 32'd0;

		phase_c     = phase_q;
		cnt_c       = cnt_q;
		w_sec_c     = w_sec_q;
		w_frac_c    = w_frac_q;
		w_cap_c     = w_cap_q;
		w_orig_c    = w_orig_q;
		remain_c    = remain_q;
		rec_total_c = rec_total_q;
		offs        = offset_q;
		emit_c      = 1'b0;

		// Restart clears everything before the byte is handled
		if (item_s1.start_flag) begin
			phase_c     = PH_GLOBAL;
			cnt_c       = 5'd0;
			w_sec_c     = 32'd0;
			w_frac_c    = 32'd0;
			w_cap_c     = 32'd0;
			w_orig_c    = 32'd0;
			remain_c    = 32'd0;
			rec_total_c = 32'd0;
			offs        = 32'd0;
		end

		// Global header already done (covers an empty global header)
		if (phase_c == PH_GLOBAL && cnt_c >= GHDR_LEN) begin
			phase_c = PH_HEADER;
			cnt_c   = 5'd0;
		end

		unique case (phase_c)
			PH_GLOBAL: begin
				cnt_inc = cnt_c + 5'd1;
				cnt_c   = cnt_inc;
				if (cnt_inc >= GHDR_LEN) begin
					phase_c = PH_HEADER;
					cnt_c   = 5'd0;
				end
			end
			PH_PAYLOAD: begin
				rem_dec  = remain_c - 32'd1;
				remain_c = rem_dec;
				if (rem_dec == 32'd0) begin
					phase_c = PH_HEADER;
					cnt_c   = 5'd0;
				end
			end
			default: begin
				// Record header byte; the unused code behaves as header
				c = cnt_c[3:0];
				unique case (c[3:2])
					WSEL_SECONDS:  w_sec_c  = merge_byte(w_sec_c, c[1:0], item_s1.data_byte);
					WSEL_FRACTION: w_frac_c = merge_byte(w_frac_c, c[1:0], item_s1.data_byte);
					WSEL_CAPTURED: w_cap_c  = merge_byte(w_cap_c, c[1:0], item_s1.data_byte);
					WSEL_ORIGINAL: w_orig_c = merge_byte(w_orig_c, c[1:0], item_s1.data_byte);
					default:       w_orig_c = w_orig_q;
				endcase
				cnt_c = {1'b0, c} + 5'd1;
				if (c == RHDR_LAST) begin
					emit_c      = 1'b1;
					rec_total_c = rec_total_c + 32'd1;
					cnt_c       = 5'd0;
					remain_c    = w_cap_c;
					phase_c     = (w_cap_c != 32'd0) ? PH_PAYLOAD : PH_HEADER;
				end
			end
		endcase

		offset_c = offs + 32'd1;

		res_data.record_number   = rec_total_c;
		res_data.ts_seconds      = w_sec_c;
		res_data.ts_fraction     = w_frac_c;
		res_data.captured_length = w_cap_c;
		res_data.original_length = w_orig_c;
		res_data.payload_offset  = offset_c;
	end

	// Stall only when a result is due and the output register is held
	assign consume  = valid_s1 && (!emit_c || res_ready);
	assign res_load = consume && emit_c;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_GLOBAL;
			cnt_q       <= 5'd0;
			w_sec_q     <= 32'd0;
			w_frac_q    <= 32'd0;
			w_cap_q     <= 32'd0;
			w_orig_q    <= 32'd0;
			remain_q    <= 32'd0;
			rec_total_q <= 32'd0;
			offset_q    <= 32'd0;
		end else if (consume) begin
			phase_q     <= phase_c;
			cnt_q       <= cnt_c;
			w_sec_q     <= w_sec_c;
			w_frac_q    <= w_frac_c;
			w_cap_q     <= w_cap_c;
			w_orig_q    <= w_orig_c;
			remain_q    <= remain_c;
			rec_total_q <= rec_total_c;
			offset_q    <= offset_c;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/prw_out_stage.sv @@
// Result register of the record walker: holds one parsed record header
// until the downstream transaction completes. Uses prw_pkg.
`default_nettype none

module prw_out_stage
	import prw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        res_load,
	input  wire prw_result_t res_data,
	output logic             res_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output prw_result_t      out_data
);

	logic        valid_q;
	prw_result_t data_q;

	assign res_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			data_q <= res_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/pcap_record_walker_top.sv @@
// Capture record walker: takes a capture file one byte per clock, skips the
// 24-byte global header, and emits each record header with its record
// number and payload offset, skipping the payload bytes. One byte is taken
// per clock; bytes pass the input register, results the output register. The
// input stalls only while a result waits in the output register and the
// next byte would complete another record header. A byte with tuser set
// restarts parsing as byte 0 of a new capture.
// Uses prw_pkg, prw_in_stage, prw_parser and prw_out_stage.
`default_nettype none

module pcap_record_walker_top
	import prw_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [7:0]             s_axis_tdata,  // [7:0] data_byte
	input  wire logic                   s_axis_tuser,  // [0] start_flag
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [31:0] record_number, [63:32] ts_seconds, [95:64] ts_fraction,
	// [127:96] captured_length, [159:128] original_length,
	// [191:160] payload_offset
	output logic [RES_TDATA_W-1:0]      m_axis_tdata
);

	prw_item_t   in_item;
	prw_item_t   item_s1;
	logic        valid_s1;
	logic        consume;
	logic        res_ready;
	logic        res_load;
	prw_result_t res_data;
	prw_result_t out_data;

	assign in_item.data_byte  = s_axis_tdata;
	assign in_item.start_flag = s_axis_tuser;

	prw_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.consume  (consume)
	);

	prw_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.consume   (consume),
		.res_ready (res_ready),
		.res_load  (res_load),
		.res_data  (res_data)
	);

	prw_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (res_load),
		.res_data  (res_data),
		.res_ready (res_ready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data)
	);

	// Struct packs record_number in the lowest bits
	assign m_axis_tdata = out_data;

endmodule

`default_nettype wire
